/* src/psrt_pkg.sv */
package psrt_pkg;

  localparam int ANS_W = 17;

  localparam logic [1:0] OP_BUILD = 2'd0;
  localparam logic [1:0] OP_PRIME = 2'd1;
  localparam logic [1:0] OP_NTH   = 2'd2;

  localparam logic [ANS_W-1:0] ANS_NONE = 17'h1FFFF;
  localparam logic [ANS_W-1:0] ANS_ONE  = 17'd1;
  localparam logic [ANS_W-1:0] ANS_ZERO = 17'd0;
  localparam logic [ANS_W-1:0] ANS_TWO  = 17'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] number;
    logic [15:0] rank_index;
  } psrt_req_t;

  typedef struct packed {
    logic ready;
    logic done;
  } psrt_status_t;

endpackage

/* src/psrt_engine.sv */
module psrt_engine import psrt_pkg::*; #(
  parameter int MAX_LIMIT = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      limit,
  input  logic             start,
  input  psrt_req_t        req,
  input  logic             take,
  output psrt_status_t     stat,
  output logic [ANS_W-1:0] result
);

  localparam int DEPTH = (MAX_LIMIT < 65535) ? MAX_LIMIT + 1 : 65536;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = AW - 1;
  localparam int NW = AW + 1;
  localparam int SW = AW + 3;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_INIT      = 4'd1;
  localparam logic [3:0] ST_SV_RD     = 4'd2;
  localparam logic [3:0] ST_SV_CHK    = 4'd3;
  localparam logic [3:0] ST_SV_MARK   = 4'd4;
  localparam logic [3:0] ST_CT_RD     = 4'd5;
  localparam logic [3:0] ST_CT_ADD    = 4'd6;
  localparam logic [3:0] ST_PR_RD     = 4'd7;
  localparam logic [3:0] ST_PR_ANS    = 4'd8;
  localparam logic [3:0] ST_NQ_LO     = 4'd9;
  localparam logic [3:0] ST_NQ_LOCHK  = 4'd10;
  localparam logic [3:0] ST_NQ_HI     = 4'd11;
  localparam logic [3:0] ST_NQ_HICHK  = 4'd12;
  localparam logic [3:0] ST_NQ_MID    = 4'd13;
  localparam logic [3:0] ST_NQ_MIDCHK = 4'd14;
  localparam logic [3:0] ST_DONE      = 4'd15;

  logic [3:0]    state;
  logic [AW-1:0] lim;
  logic [AW-1:0] built_lim;
  logic          built;
  logic [NW-1:0] n;
  logic [SW-1:0] p;
  logic [SW-1:0] sq;
  logic [SW-1:0] m;
  logic [AW-1:0] count;
  logic [15:0]   num;
  logic [15:0]   rank;
  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [IW-1:0] mid;
  logic [AW-1:0] cnt_lo;
  logic [AW-1:0] cnt_hi;

  logic          flags [DEPTH];
  logic [AW-1:0] counts [DEPTH/2];

  logic          flag_we;
  logic [AW-1:0] flag_waddr;
  logic          flag_wdata;
  logic [AW-1:0] flag_raddr;
  logic          flag_rdata;
  logic          cnt_we;
  logic [IW-1:0] cnt_waddr;
  logic [AW-1:0] cnt_wdata;
  logic [IW-1:0] cnt_raddr;
  logic [AW-1:0] cnt_rdata;

  logic [AW-1:0] lim_eff;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid_w;
  logic [AW-1:0] count_next;
  logic [16:0]   rank_x;
  logic [16:0]   rd_x;

  assign lim_eff = (32'(limit) > MAX_LIMIT) ? AW'(MAX_LIMIT) : AW'(limit);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_w = mid_sum[IW:1];
  assign count_next = count + AW'(flag_rdata);
  assign rank_x = 17'(rank);
  assign rd_x = 17'(cnt_rdata);

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flags[flag_waddr] <= flag_wdata;
    end
    flag_rdata <= flags[flag_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= counts[cnt_raddr];
  end

  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = n[AW-1:0];
    flag_wdata = (n[0] && n >= NW'(3)) || n == NW'(2);
    cnt_we     = 1'b0;
    cnt_waddr  = n[AW-1:1];
    cnt_wdata  = count_next;
    case (state)
      ST_SV_RD: flag_raddr = p[AW-1:0];
      ST_CT_RD: flag_raddr = n[AW-1:0];
      default:  flag_raddr = num[AW-1:0];
    endcase
    case (state)
      ST_NQ_HI:  cnt_raddr = hi;
      ST_NQ_MID: cnt_raddr = mid_w;
      default:   cnt_raddr = lo;
    endcase
    if (state == ST_INIT) begin
      flag_we = 1'b1;
    end
    if (state == ST_SV_MARK && m <= SW'(lim)) begin
      flag_we    = 1'b1;
      flag_waddr = m[AW-1:0];
      flag_wdata = 1'b0;
    end
    if (state == ST_CT_ADD) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      built     <= 1'b0;
      built_lim <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            num  <= req.number;
            rank <= req.rank_index;
            case (req.operation)
              OP_BUILD: begin
                lim   <= lim_eff;
                n     <= '0;
                state <= ST_INIT;
              end
              OP_PRIME: begin
                if (built && 17'(req.number) <= 17'(built_lim)) begin
                  state <= ST_PR_RD;
                end else begin
                  result <= ANS_NONE;
                  state  <= ST_DONE;
                end
              end
              OP_NTH: begin
                if (!built) begin
                  result <= ANS_NONE;
                  state  <= ST_DONE;
                end else if (req.rank_index == 16'd1) begin
                  result <= ANS_TWO;
                  state  <= ST_DONE;
                end else if (built_lim < AW'(3)) begin
                  result <= ANS_NONE;
                  state  <= ST_DONE;
                end else begin
                  lo    <= IW'(1);
                  hi    <= IW'((built_lim - AW'(1)) >> 1);
                  state <= ST_NQ_LO;
                end
              end
              default: begin
                result <= ANS_NONE;
                state  <= ST_DONE;
              end
            endcase
          end
        end
        ST_INIT: begin
          if (n == NW'(lim)) begin
            p     <= SW'(3);
            sq    <= SW'(9);
            state <= ST_SV_RD;
          end else begin
            n <= n + NW'(1);
          end
        end
        ST_SV_RD: begin
          if (sq > SW'(lim)) begin
            count <= (lim >= AW'(2)) ? AW'(1) : AW'(0);
            n     <= NW'(3);
            state <= ST_CT_RD;
          end else begin
            state <= ST_SV_CHK;
          end
        end
        ST_SV_CHK: begin
          if (flag_rdata) begin
            m     <= sq;
            state <= ST_SV_MARK;
          end else begin
            p     <= p + SW'(2);
            sq    <= sq + (p << 2) + SW'(4);
            state <= ST_SV_RD;
          end
        end
        ST_SV_MARK: begin
          if (m <= SW'(lim)) begin
            m <= m + (p << 1);
          end else begin
            p     <= p + SW'(2);
            sq    <= sq + (p << 2) + SW'(4);
            state <= ST_SV_RD;
          end
        end
        ST_CT_RD: begin
          if (n > NW'(lim)) begin
            built     <= 1'b1;
            built_lim <= lim;
            result    <= ANS_W'(count);
            state     <= ST_DONE;
          end else begin
            state <= ST_CT_ADD;
          end
        end
        ST_CT_ADD: begin
          count <= count_next;
          n     <= n + NW'(2);
          state <= ST_CT_RD;
        end
        ST_PR_RD: begin
          state <= ST_PR_ANS;
        end
        ST_PR_ANS: begin
          result <= flag_rdata ? ANS_ONE : ANS_ZERO;
          state  <= ST_DONE;
        end
        ST_NQ_LO: begin
          state <= ST_NQ_LOCHK;
        end
        ST_NQ_LOCHK: begin
          cnt_lo <= cnt_rdata;
          if (rd_x == rank_x) begin
            result <= ANS_W'({lo, 1'b1});
            state  <= ST_DONE;
          end else if (lo == hi) begin
            result <= ANS_NONE;
            state  <= ST_DONE;
          end else begin
            state <= ST_NQ_HI;
          end
        end
        ST_NQ_HI: begin
          state <= ST_NQ_HICHK;
        end
        ST_NQ_HICHK: begin
          cnt_hi <= cnt_rdata;
          if (rank_x > rd_x) begin
            result <= ANS_NONE;
            state  <= ST_DONE;
          end else begin
            state <= ST_NQ_MID;
          end
        end
        ST_NQ_MID: begin
          mid   <= mid_w;
          state <= ST_NQ_MIDCHK;
        end
        ST_NQ_MIDCHK: begin
          if (17'(cnt_lo) < rank_x && rd_x >= rank_x) begin
            hi     <= mid;
            cnt_hi <= cnt_rdata;
            state  <= ST_NQ_MID;
          end else if (lo == mid) begin
            result <= (17'(cnt_hi) == rank_x) ? ANS_W'({hi, 1'b1}) : ANS_NONE;
            state  <= ST_DONE;
          end else begin
            lo     <= mid;
            cnt_lo <= cnt_rdata;
            state  <= ST_NQ_MID;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.ready = (state == ST_IDLE);
  assign stat.done  = (state == ST_DONE);

endmodule

/* src/prime_sieve_rank_table_unit.sv */
// Channel    Handshake            Payload
// request    in_valid / in_stall  operation, number, rank_index
// answer     out_valid / out_stall answer (signed)
// config     limit_wr_en          limit_wr_data
//
// Build: seed the flag table, then sieve each odd candidate up to sqrt(lim),
//   crossing off its multiples when it is still marked prime, then store the
//   running count of primes for each odd number; one flag read port and one
//   flag write port.
// Primality: one flag table read. Nth prime: a binary search over the running
//   counts, one count memory read per search step.
// Reset clears control state; tables are invalid until the first build.
// A finished answer waits in the output register under out_stall while the
//   next request is taken.
module prime_sieve_rank_table_unit import psrt_pkg::*; #(
  parameter int MAX_LIMIT = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               limit_wr_en,
  input  logic [15:0]        limit_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [15:0]        number,
  input  logic [15:0]        rank_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] answer
);

  logic             [15:0] limit;
  psrt_req_t               req;
  psrt_status_t            stat;
  logic [ANS_W-1:0]        result;
  logic                    start;
  logic                    load;

  assign req.operation  = operation;
  assign req.number     = number;
  assign req.rank_index = rank_index;

  assign in_stall = !stat.ready;
  assign start    = in_valid && stat.ready;
  assign load     = stat.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 16'hFFFF;
    end else if (limit_wr_en) begin
      limit <= limit_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      answer <= $signed(result);
    end
  end

  psrt_engine #(
    .MAX_LIMIT(MAX_LIMIT)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .limit  (limit),
    .start  (start),
    .req    (req),
    .take   (load),
    .stat   (stat),
    .result (result)
  );

endmodule
